// ===== sv/infix_to_postfix_operator_stack_defines.svh =====
// Assertion macros used by the checker file of the operator stack block.
`ifndef INFIX_TO_POSTFIX_OPERATOR_STACK_DEFINES_SVH
`define INFIX_TO_POSTFIX_OPERATOR_STACK_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define ITP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("itp assertion failed");

// Next-cycle implication, disabled while in reset.
`define ITP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("itp assertion failed");

`endif

// ===== sv/itp_pkg.sv =====
// Shared constants, types and the precedence table of the operator stack block.
package itp_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);

  localparam logic [2:0] ACT_OPERAND  = 3'd0;
  localparam logic [2:0] ACT_LEFT     = 3'd1;
  localparam logic [2:0] ACT_RIGHT    = 3'd2;
  localparam logic [2:0] ACT_OPERATOR = 3'd3;
  localparam logic [2:0] ACT_END      = 3'd4;

  localparam logic [3:0] LEFT_MARK   = 4'd15;
  localparam logic [3:0] MAX_OP_CODE = 4'd12;
  localparam logic [3:0] OP_NONE     = 4'd0;

  localparam logic [1:0] KIND_PUSH     = 2'd0;
  localparam logic [1:0] KIND_APPLY    = 2'd1;
  localparam logic [1:0] KIND_OVERFLOW = 2'd2;
  localparam logic [1:0] KIND_UNUSED   = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH
  } state_t;

  // length 5; mul/div/intdiv 4; add/sub 3; concat 2; relations 1
  function automatic logic [2:0] prec_of(input logic [3:0] code);
    logic [2:0] p;
    unique case (code)
      4'd0, 4'd1:               p = 3'd3;
      4'd2, 4'd3, 4'd4:         p = 3'd4;
      4'd5:                     p = 3'd2;
      4'd6:                     p = 3'd5;
      4'd7, 4'd8, 4'd9, 4'd10,
      4'd11, 4'd12:             p = 3'd1;
      default:                  p = 3'd0;
    endcase
    return p;
  endfunction

endpackage

// ===== sv/infix_to_postfix_operator_stack.sv =====
// Path: an operand word goes from the token latch to the pending word to the output register;
//   each pop of a popping token is a loop step of its own. One token at a time: in_ready only in idle.
// One stack read and compare per cycle while no pop stalls; a bracket dropped at end takes a step.
// Back-pressure on out_ready stalls a pop or the flush until the output register is free.
// Reset: synchronous, active low; clears sequencer, stack count and valid flags.
//   Stack entries are not cleared: only entries below the count are ever read.
module infix_to_postfix_operator_stack (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_action,
  input  logic [3:0]           in_operator_code,
  input  logic [2:0]           in_operand_kind,
  input  logic [15:0]          in_operand_handle,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_result_kind,
  output logic [3:0]           out_operator,
  output logic [2:0]           out_operand_kind,
  output logic [15:0]          out_operand_handle,
  output logic                 out_last
);
  import itp_pkg::*;

  // Sequencer state
  state_t state_r, state_nxt;

  // Token latched at accept
  logic [2:0]  act_r;
  logic [3:0]  code_r;
  logic [2:0]  okind_r;
  logic [15:0] handle_r;

  // Operator stack: entries plus fill count
  logic [3:0]       stack_mem [STACK_DEPTH];
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push_en;
  logic [3:0]       push_data;

  // Pending word: held back until we know whether it is the last one
  logic        pend_v_r, pend_v_nxt;
  logic [1:0]  pend_kind_r, pend_kind_nxt;
  logic [3:0]  pend_op_r, pend_op_nxt;
  logic [2:0]  pend_okind_r, pend_okind_nxt;
  logic [15:0] pend_handle_r, pend_handle_nxt;

  // Output register
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_kind_r;
  logic [3:0]  out_op_r;
  logic [2:0]  out_okind_r;
  logic [15:0] out_handle_r;
  logic        out_last_r;
  logic        out_load, out_last_nxt;
  logic        out_free;

  // Step decode
  logic [CNT_W-1:0] cnt_m1;
  logic [IDX_W-1:0] top_idx;
  logic [3:0]       top;
  logic             empty, full, top_mark, code_ok;
  logic             do_pop, do_drop, stall, finish;

  assign in_ready = (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_ready;

  assign cnt_m1   = count_r - CNT_W'(1);
  assign top_idx  = cnt_m1[IDX_W-1:0];
  assign top      = stack_mem[top_idx];
  assign empty    = (count_r == '0);
  assign full     = (count_r == CNT_W'(STACK_DEPTH));
  assign top_mark = (top == LEFT_MARK);
  assign code_ok  = (code_r <= MAX_OP_CODE);

  // One loop step: pop an operator, drop a bracket at end, or finish the token.
  // The precedence compare is the shared unit reused on every operator pop.
  always_comb begin
    do_pop  = 1'b0;
    do_drop = 1'b0;
    unique case (act_r)
      ACT_RIGHT: do_pop = !empty && !top_mark;
      ACT_OPERATOR: do_pop = code_ok && !empty && !top_mark &&
                             (prec_of(top) >= prec_of(code_r));
      ACT_END: begin
        do_pop  = !empty && !top_mark;
        do_drop = !empty && top_mark;
      end
      default: ;
    endcase
    stall  = do_pop && pend_v_r && !out_free;
    finish = !do_pop && !do_drop;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_RUN;
      ST_RUN:   if (finish) state_nxt = pend_v_nxt ? ST_FLUSH : ST_IDLE;
      ST_FLUSH: if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Datapath controls
  always_comb begin
    count_nxt       = count_r;
    push_en         = 1'b0;
    push_data       = LEFT_MARK;
    pend_v_nxt      = pend_v_r;
    pend_kind_nxt   = pend_kind_r;
    pend_op_nxt     = pend_op_r;
    pend_okind_nxt  = pend_okind_r;
    pend_handle_nxt = pend_handle_r;
    out_load        = 1'b0;
    out_last_nxt    = 1'b0;

    unique case (state_r)
      ST_IDLE: ;
      ST_RUN: begin
        if (do_pop) begin
          if (!stall) begin
            // earlier pending word is not the last: ship it
            out_load        = pend_v_r;
            pend_v_nxt      = 1'b1;
            pend_kind_nxt   = KIND_APPLY;
            pend_op_nxt     = top;
            pend_okind_nxt  = 3'd0;
            pend_handle_nxt = 16'd0;
            count_nxt       = cnt_m1;
          end
        end else if (do_drop) begin
          count_nxt = cnt_m1;
        end else begin
          unique case (act_r)
            ACT_OPERAND: begin
              pend_v_nxt      = 1'b1;
              pend_kind_nxt   = KIND_PUSH;
              pend_op_nxt     = OP_NONE;
              pend_okind_nxt  = okind_r;
              pend_handle_nxt = handle_r;
            end
            ACT_LEFT, ACT_OPERATOR: begin
              if (act_r == ACT_LEFT || code_ok) begin
                if (!full) begin
                  push_en   = 1'b1;
                  push_data = (act_r == ACT_LEFT) ? LEFT_MARK : code_r;
                  count_nxt = count_r + CNT_W'(1);
                end else begin
                  // full stack means nothing was popped, so pend is free
                  pend_v_nxt      = 1'b1;
                  pend_kind_nxt   = KIND_OVERFLOW;
                  pend_op_nxt     = (act_r == ACT_LEFT) ? OP_NONE : code_r;
                  pend_okind_nxt  = 3'd0;
                  pend_handle_nxt = 16'd0;
                end
              end
            end
            ACT_RIGHT: if (!empty) count_nxt = cnt_m1;  // discard the bracket
            default: ;
          endcase
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_last_nxt = 1'b1;
          pend_v_nxt   = 1'b0;
        end
      end
      default: ;
    endcase

    out_valid_nxt = out_load ? 1'b1 : (out_valid_r && !out_ready);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      act_r    <= in_action;
      code_r   <= in_operator_code;
      okind_r  <= in_operand_kind;
      handle_r <= in_operand_handle;
    end
    pend_kind_r   <= pend_kind_nxt;
    pend_op_r     <= pend_op_nxt;
    pend_okind_r  <= pend_okind_nxt;
    pend_handle_r <= pend_handle_nxt;
    if (out_load) begin
      out_kind_r   <= pend_kind_r;
      out_op_r     <= pend_op_r;
      out_okind_r  <= pend_okind_r;
      out_handle_r <= pend_handle_r;
      out_last_r   <= out_last_nxt;
    end
  end

  // Stack write port
  always_ff @(posedge clk) begin
    if (push_en) stack_mem[count_r[IDX_W-1:0]] <= push_data;
  end

  assign out_valid          = out_valid_r;
  assign out_result_kind    = out_kind_r;
  assign out_operator       = out_op_r;
  assign out_operand_kind   = out_okind_r;
  assign out_operand_handle = out_handle_r;
  assign out_last           = out_last_r;

endmodule

// ===== sv/itp_checker.sv =====
// Port-level checker for the operator stack block, bound to the top level.
`include "infix_to_postfix_operator_stack_defines.svh"

module itp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_result_kind,
  input logic [3:0]  out_operator,
  input logic        out_last
);
  import itp_pkg::*;

  // one token at a time: busy right after a word is taken
  `ITP_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // a stalled output word holds
  `ITP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_operator))

  // only three result kinds exist
  `ITP_ASSERT_IMPL(a_kind_legal, out_valid, out_result_kind != KIND_UNUSED)

  // push and overflow words are always alone, hence last
  `ITP_ASSERT_IMPL(a_single_last,
    out_valid && (out_result_kind == KIND_PUSH || out_result_kind == KIND_OVERFLOW),
    out_last)

endmodule

bind infix_to_postfix_operator_stack itp_checker u_itp_checker (.*);
